@@ src/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 stream decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int INDEX_BITS_DEF = 24;
	localparam int CODE_POINT_W   = 21;
	localparam int CHAR_INDEX_W   = 24;
	localparam int PARTIAL_W      = 15;
	localparam int IN_TDATA_W     = 8;
	localparam int OUT_TDATA_W    = 48;

	localparam logic [CODE_POINT_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
	localparam logic [CODE_POINT_W-1:0] MAX_SCALAR       = 21'h10FFFF;
	localparam logic [CODE_POINT_W-1:0] SURROGATE_LO     = 21'h00D800;
	localparam logic [CODE_POINT_W-1:0] SURROGATE_HI     = 21'h00DFFF;

	typedef enum logic [2:0] {
		PH_ACCEPT = 3'd0,
		PH_ONE    = 3'd1,
		PH_TWO    = 3'd2,
		PH_E0     = 3'd3,
		PH_ED     = 3'd4,
		PH_THREE  = 3'd5,
		PH_F0     = 3'd6,
		PH_F4     = 3'd7
	} phase_t;

	typedef struct packed {
		logic       end_of_string;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic                    last_of_string;
		logic                    was_replaced;
		logic [CHAR_INDEX_W-1:0] char_index;
		logic [CODE_POINT_W-1:0] code_point;
	} result_t;

endpackage

@@ src/utf8d_in.sv @@
// ----------------------------------------------------------------------------
// utf8d_in
// input register stage holding one accepted byte
// ----------------------------------------------------------------------------
module utf8d_in
	import utf8d_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                  s_axis_tlast,
	input  logic                  adv,
	output logic                  valid_s1,
	output byte_item_t            item_s1
);

	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte     <= s_axis_tdata;
			item_s1.end_of_string <= s_axis_tlast;
		end
	end

endmodule

@@ src/utf8d_dec.sv @@
// ----------------------------------------------------------------------------
// utf8d_dec
// validating decode of one byte against the pending sequence state
// ----------------------------------------------------------------------------
module utf8d_dec
	import utf8d_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  byte_item_t item_s1,
	output logic       emit,
	output result_t    res
);

	phase_t                  phase_q, nxt_phase;
	logic [PARTIAL_W-1:0]    partial_q, nxt_partial;
	logic [INDEX_BITS-1:0]   cnt_q;
	logic [CHAR_INDEX_W-1:0] idx_ext;
	logic [CODE_POINT_W-1:0] cont_val;
	logic [CODE_POINT_W-1:0] cp;
	logic [7:0]              lo, hi;
	logic [7:0]              b;
	logic                    bad;
	logic                    last;

	assign b        = item_s1.data_byte;
	assign last     = item_s1.end_of_string;
	assign cont_val = {partial_q, b[5:0]};

	if (INDEX_BITS >= CHAR_INDEX_W) begin : g_idx_trunc
		assign idx_ext = cnt_q[CHAR_INDEX_W-1:0];
	end else begin : g_idx_ext
		assign idx_ext = {{(CHAR_INDEX_W-INDEX_BITS){1'b0}}, cnt_q};
	end

	always_comb begin
		lo = 8'h80;
		hi = 8'hBF;
		case (phase_q)
			PH_E0: lo = 8'hA0;
			PH_ED: hi = 8'h9F;
			PH_F0: lo = 8'h90;
			PH_F4: hi = 8'h8F;
			default: ;
		endcase
	end

	always_comb begin
		nxt_phase   = phase_q;
		nxt_partial = partial_q;
		emit        = 1'b0;
		bad         = 1'b0;
		cp          = '0;
		if (phase_q == PH_ACCEPT) begin
			if (b < 8'h80) begin
				cp   = {13'd0, b};
				emit = 1'b1;
			end else if (b inside {[8'hC2:8'hDF]}) begin
				nxt_partial = {10'd0, b[4:0]};
				nxt_phase   = PH_ONE;
			end else if (b inside {[8'hE0:8'hEF]}) begin
				nxt_partial = {11'd0, b[3:0]};
				nxt_phase   = (b == 8'hE0) ? PH_E0 : (b == 8'hED) ? PH_ED : PH_TWO;
			end else if (b inside {[8'hF0:8'hF4]}) begin
				nxt_partial = {12'd0, b[2:0]};
				nxt_phase   = (b == 8'hF0) ? PH_F0 : (b == 8'hF4) ? PH_F4 : PH_THREE;
			end else begin
				bad = 1'b1;
			end
		end else if (b < lo || b > hi) begin
			bad = 1'b1;
		end else if (phase_q == PH_ONE) begin
			cp   = cont_val;
			emit = 1'b1;
		end else begin
			nxt_partial = cont_val[PARTIAL_W-1:0];
			nxt_phase   = (phase_q == PH_THREE || phase_q == PH_F0 || phase_q == PH_F4)
				? PH_TWO : PH_ONE;
		end

		if (bad) begin
			cp   = REPLACEMENT_CHAR;
			emit = 1'b1;
		end
		if (last && !emit) begin
			cp   = REPLACEMENT_CHAR;
			bad  = 1'b1;
			emit = 1'b1;
		end
		if (emit) begin
			nxt_phase   = PH_ACCEPT;
			nxt_partial = '0;
		end

		res.code_point     = cp;
		res.char_index     = idx_ext;
		res.was_replaced   = bad;
		res.last_of_string = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ACCEPT;
			partial_q <= '0;
			cnt_q     <= '0;
		end else if (adv) begin
			phase_q   <= nxt_phase;
			partial_q <= nxt_partial;
			if (emit) begin
				if (last) begin
					cnt_q <= '0;
				end else if (cnt_q != {INDEX_BITS{1'b1}}) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last |-> emit)
		else $error("final byte produced no result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last |=> phase_q == PH_ACCEPT && cnt_q == '0 && partial_q == '0)
		else $error("state not cleared after final byte");

	a_valid_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && !bad |-> cp <= MAX_SCALAR && (cp < SURROGATE_LO || cp > SURROGATE_HI))
		else $error("accepted sequence decoded to a non-scalar value");
`endif

endmodule

@@ src/utf8d_out.sv @@
// ----------------------------------------------------------------------------
// utf8d_out
// result register toward the output stream
// ----------------------------------------------------------------------------
module utf8d_out
	import utf8d_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  logic                   emit,
	input  result_t                res,
	output logic                   adv,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast
);

	result_t res_q;
	logic    load;

	assign adv  = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign load = adv && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W-CODE_POINT_W-CHAR_INDEX_W){1'b0}},
		res_q.char_index, res_q.code_point};
	assign m_axis_tuser = res_q.was_replaced;
	assign m_axis_tlast = res_q.last_of_string;

endmodule

@@ src/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// strict utf-8 byte stream decoder emitting code points with their index
// ----------------------------------------------------------------------------
// input stream: one byte per beat in s_axis_tdata, s_axis_tlast marks the
// final byte of a string. output stream: one beat per completed code point,
// per rejected byte and per string that ends mid-sequence; m_axis_tuser
// flags a replacement character and m_axis_tlast is set on the beat caused
// by the final byte.
// a byte is taken into an input register, decoded against the pending
// sequence state in one pass and the result is loaded into the output
// register once that register is free or being read out.
// throughput is one byte per cycle while m_axis_tready stays high; the
// decode stage updates its sequence state as each byte is taken.
// reset returns the decoder to the accept state with the index at zero and
// empties both registers.
// when the receiver stalls with a result held, the input register keeps its
// byte, also one that produces no result, and s_axis_tready drops once it is
// full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
	import utf8d_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_byte
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // code_point, char_index
	output logic                   m_axis_tuser,   // was_replaced
	output logic                   m_axis_tlast
);

	byte_item_t item_s1;
	result_t    res;
	logic       valid_s1;
	logic       adv;
	logic       emit;

	utf8d_in u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.adv           (adv),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	utf8d_dec #(
		.INDEX_BITS (INDEX_BITS)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.emit    (emit),
		.res     (res)
	);

	utf8d_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.emit          (emit),
		.res           (res),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
